>>> rtl/bcs_pkg.sv
// Shared types and constants for the brightest column steering block.
// Used by every module under rtl but bcs_fifo; depends on nothing else.
package bcs_pkg;

    localparam int DEFAULT_MAX_ROW_WIDTH = 2048;

    localparam int ROW_IDX_W = 13;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_W     = 32;
    localparam int DEN_W     = 17;
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPENING_LIMIT = 2'd2;

    localparam logic [CFG_W-1:0] TURN_GAIN_RESET     = 16'd256;
    localparam logic [CFG_W-1:0] FORWARD_SPEED_RESET = 16'd655;
    localparam logic [CFG_W-1:0] OPENING_LIMIT_RESET = 16'd6554;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    typedef enum logic {
        JOB_ROW  = 1'b0,
        JOB_TICK = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t            kind;
        logic [ROW_IDX_W-1:0] column;
        logic [ROW_IDX_W-1:0] width;
    } bcs_job_t;

    typedef struct packed {
        logic signed [15:0] angular_rate;
        logic [15:0]        linear_rate;
    } bcs_result_t;

    typedef struct packed {
        logic [CFG_W-1:0] turn_gain;
        logic [CFG_W-1:0] forward_speed;
        logic [CFG_W-1:0] opening_limit;
    } bcs_cfg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TICK,
        B_DIV,
        B_DIV_DONE,
        B_EMIT
    } back_state_t;

endpackage

>>> rtl/bcs_fifo.sv
// Small first-in first-out queue built from registers.
// Generic in width and depth; no package dependencies.
module bcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("Queue count exceeds its depth.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> !empty)
        else $error("Queue is empty right after a push.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Empty queue has unequal pointers.");

endmodule

>>> rtl/bcs_front.sv
// Front end: tracks the brightest pixel of the current row, one item per cycle while
// the job queue is not full. Emits a row job at row end and a tick job per tick; uses bcs_pkg.
module bcs_front #(
    parameter int MAX_ROW_WIDTH = bcs_pkg::DEFAULT_MAX_ROW_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              command,
    input  logic [7:0]        pixel,
    input  logic              row_end,
    input  logic              job_full,
    output logic              job_push,
    output bcs_pkg::bcs_job_t job
);
    import bcs_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROW_WIDTH + 1);
    localparam int COL_W = $clog2(MAX_ROW_WIDTH);

    logic [7:0]       best_value_reg, best_value_next;
    logic [COL_W-1:0] best_column_reg, best_column_next;
    logic [CNT_W-1:0] column_count_reg, column_count_next;
    logic             accept;
    logic             is_tick;

    assign accept  = in_valid && !job_full;
    assign is_tick = (cmd_t'(command) == CMD_TICK);

    always_comb
    begin
        best_value_next   = best_value_reg;
        best_column_next  = best_column_reg;
        column_count_next = column_count_reg;
        job_push          = 1'b0;
        job.kind          = JOB_TICK;
        job.column        = '0;
        job.width         = '0;
        if (accept && !is_tick)
        begin
            if (column_count_reg < CNT_W'(MAX_ROW_WIDTH))
            begin
                if (column_count_reg == '0 || pixel > best_value_reg)
                begin
                    best_value_next  = pixel;
                    best_column_next = COL_W'(column_count_reg);
                end
                column_count_next = column_count_reg + 1'b1;
            end
            if (row_end)
            begin
                job_push          = 1'b1;
                job.kind          = JOB_ROW;
                job.column        = ROW_IDX_W'(best_column_next);
                job.width         = ROW_IDX_W'(column_count_next);
                best_value_next   = '0;
                best_column_next  = '0;
                column_count_next = '0;
            end
        end
        else if (accept)
        begin
            job_push = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_value_reg   <= '0;
            best_column_reg  <= '0;
            column_count_reg <= '0;
        end
        else
        begin
            best_value_reg   <= best_value_next;
            best_column_reg  <= best_column_next;
            column_count_reg <= column_count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        column_count_reg <= CNT_W'(MAX_ROW_WIDTH))
        else $error("Column count runs past the row limit.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && job.kind == JOB_ROW) |->
        (job.width != '0 && job.column < job.width))
        else $error("Row job with an impossible column or width.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (column_count_reg != '0) |-> (CNT_W'(best_column_reg) < column_count_reg))
        else $error("Best column lies beyond the columns seen.");

endmodule

>>> rtl/bcs_back.sv
// Back end: turns row jobs into the stored offset and tick jobs into results.
// One shared restoring divider and one multiplier; uses bcs_pkg.
module bcs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bcs_pkg::bcs_cfg_t    cfg,
    input  logic                 job_empty,
    input  bcs_pkg::bcs_job_t    job,
    output logic                 job_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output bcs_pkg::bcs_result_t res
);
    import bcs_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    back_state_t       state_reg, state_next;
    logic [15:0]       steer_offset_reg, steer_offset_next;
    logic [4:0]        div_cnt_reg, div_cnt_next;
    logic [DEN_W-1:0]  div_rem_reg, div_rem_next;
    logic [DEN_W-1:0]  div_den_reg, div_den_next;
    logic [DIV_W-1:0]  div_quo_reg, div_quo_next;
    logic [32:0]       mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic              row_op_reg, row_op_next;
    logic [15:0]       ang_reg, ang_next;
    logic [15:0]       lin_reg, lin_next;

    logic signed [15:0] off_s;
    logic [16:0]        abs_off;
    logic [17:0]        lin_abs;
    logic               lin_en;
    logic [DEN_W-1:0]   lin_den;
    logic [DIV_W-1:0]   lin_num;
    logic [13:0]        two_col;
    logic [13:0]        row_n;
    logic               row_neg;
    logic [13:0]        row_dmag;
    logic [DEN_W:0]     div_shift;
    logic               div_ge;
    logic [33:0]        ang_sum;
    logic [18:0]        ang_mag;

    assign off_s   = $signed(steer_offset_reg);
    assign abs_off = off_s[15] ? 17'(-$signed({off_s[15], off_s})) : {1'b0, off_s};
    assign lin_abs = {abs_off, 1'b0};
    assign lin_en  = (lin_abs < 18'(cfg.opening_limit)) && (cfg.forward_speed != '0);
    assign lin_den = DEN_W'(lin_abs) + DEN_W'(cfg.forward_speed);
    assign lin_num = {cfg.forward_speed, 16'd0} + DIV_W'(lin_den[DEN_W-1:1]);

    assign two_col  = {job.column, 1'b0};
    assign row_n    = 14'(job.width);
    assign row_neg  = two_col < row_n;
    assign row_dmag = row_neg ? row_n - two_col : two_col - row_n;

    assign div_shift = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_ge    = div_shift >= {1'b0, div_den_reg};

    assign ang_sum = 34'(mag_reg) + 34'd16384;
    assign ang_mag = ang_sum[33:15];

    assign res.angular_rate = $signed(ang_reg);
    assign res.linear_rate  = lin_reg;

    always_comb
    begin
        state_next        = state_reg;
        steer_offset_next = steer_offset_reg;
        div_cnt_next      = div_cnt_reg;
        div_rem_next      = div_rem_reg;
        div_den_next      = div_den_reg;
        div_quo_next      = div_quo_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        row_op_next       = row_op_reg;
        ang_next          = ang_reg;
        lin_next          = lin_reg;
        job_pop           = 1'b0;
        res_push          = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop = 1'b1;
                    if (job.kind == JOB_ROW)
                    begin
                        row_op_next  = 1'b1;
                        neg_next     = row_neg;
                        div_quo_next = DIV_W'({row_dmag[12:0], 15'd0}) + DIV_W'(row_n);
                        div_den_next = DEN_W'({row_n, 1'b0});
                        div_rem_next = '0;
                        div_cnt_next = '0;
                        state_next   = B_DIV;
                    end
                    else
                    begin
                        row_op_next = 1'b0;
                        neg_next    = !off_s[15] && (off_s != '0);
                        mag_next    = 33'(abs_off) * 33'(cfg.turn_gain);
                        state_next  = B_TICK;
                    end
                end
            end
            B_TICK:
            begin
                if (neg_reg)
                begin
                    ang_next = (ang_mag > 19'd32768) ? 16'h8000 : 16'(-ang_mag);
                end
                else
                begin
                    ang_next = (ang_mag > 19'd32767) ? 16'h7FFF : ang_mag[15:0];
                end
                if (lin_en)
                begin
                    div_quo_next = lin_num;
                    div_den_next = lin_den;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    state_next   = B_DIV;
                end
                else
                begin
                    lin_next   = '0;
                    state_next = B_EMIT;
                end
            end
            B_DIV:
            begin
                div_rem_next = div_ge ? DEN_W'(div_shift - {1'b0, div_den_reg})
                                      : DEN_W'(div_shift);
                div_quo_next = {div_quo_reg[DIV_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    state_next = B_DIV_DONE;
                end
            end
            B_DIV_DONE:
            begin
                if (row_op_reg)
                begin
                    steer_offset_next = neg_reg ? 16'(-div_quo_reg[15:0]) : div_quo_reg[15:0];
                    state_next        = B_IDLE;
                end
                else
                begin
                    lin_next   = (div_quo_reg[31:16] != '0) ? 16'hFFFF : div_quo_reg[15:0];
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            steer_offset_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            steer_offset_reg <= steer_offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_cnt_reg <= div_cnt_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_quo_reg <= div_quo_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        row_op_reg  <= row_op_next;
        ang_reg     <= ang_next;
        lin_reg     <= lin_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (div_den_reg != '0))
        else $error("Divider runs with a zero divisor.");
    assert property (@(posedge clk) disable iff (!rst_n)
        ($signed(steer_offset_reg) >= -16'sd16384) && ($signed(steer_offset_reg) <= 16'sd16383))
        else $error("Stored offset is out of range.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT && !res_full) |=> (state_reg == B_IDLE))
        else $error("Result was not handed off.");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (state_reg == B_IDLE && !job_empty))
        else $error("Job taken while the back end is busy.");

endmodule

>>> rtl/brightest_column_steering_core.sv
// Top level of the brightest column steering block: configuration registers,
// front end, job queue, back end and result queue. Uses bcs_pkg and all rtl modules.
//
//  Channel   Handshake                Payload
//  input     push / full              command, pixel, row_end
//  result    empty / pop              angular_rate, linear_rate
//  config    cfg_write                cfg_index, cfg_data
//
// Pixel items leave no result; the front end takes them while the job queue is not full.
// A row end queues a job that the back end runs through its 32-step divider.
// A tick takes the back end through its tick and emit states, and through the divider when the forward rate needs it.
// The input stalls (full) only while the four-entry job queue is full.
// Reset clears all control state and takes effect at once; there is no clearing pass.
module brightest_column_steering_core #(
    parameter int MAX_ROW_WIDTH = bcs_pkg::DEFAULT_MAX_ROW_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            command,
    input  logic [7:0]                      pixel,
    input  logic                            row_end,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [15:0]              angular_rate,
    output logic [15:0]                     linear_rate,
    input  logic                            cfg_write,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcs_pkg::CFG_W-1:0]       cfg_data
);
    import bcs_pkg::*;

    bcs_cfg_t    cfg_reg, cfg_next;
    bcs_job_t    front_job;
    bcs_job_t    back_job;
    bcs_result_t back_res;
    bcs_result_t out_res;
    logic        job_push;
    logic        job_full;
    logic        job_pop;
    logic        job_empty;
    logic        res_push;
    logic        res_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TURN_GAIN:     cfg_next.turn_gain     = cfg_data;
                REG_FORWARD_SPEED: cfg_next.forward_speed = cfg_data;
                REG_OPENING_LIMIT: cfg_next.opening_limit = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turn_gain     <= TURN_GAIN_RESET;
            cfg_reg.forward_speed <= FORWARD_SPEED_RESET;
            cfg_reg.opening_limit <= OPENING_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bcs_front #(
        .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(push),
        .command (command),
        .pixel   (pixel),
        .row_end (row_end),
        .job_full(job_full),
        .job_push(job_push),
        .job     (front_job)
    );

    bcs_fifo #(
        .WIDTH($bits(bcs_job_t)),
        .DEPTH(JOB_DEPTH)
    ) u_job_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (job_push),
        .wdata(front_job),
        .full (job_full),
        .pop  (job_pop),
        .rdata(back_job),
        .empty(job_empty)
    );

    bcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .job_empty(job_empty),
        .job      (back_job),
        .job_pop  (job_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (back_res)
    );

    bcs_fifo #(
        .WIDTH($bits(bcs_result_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(back_res),
        .full (res_full),
        .pop  (pop),
        .rdata(out_res),
        .empty(empty)
    );

    assign full         = job_full;
    assign angular_rate = out_res.angular_rate;
    assign linear_rate  = out_res.linear_rate;

endmodule
